>>> hdl/srl_pkg.sv
// Shared types, constants and codes for the sliding window rate limiter.
package srl_pkg;

  // Default sizes of the bucket table and the per-bucket timestamp ring.
  localparam int BUCKETS_DEF    = 64;
  localparam int RING_DEPTH_DEF = 16;

  // Fixed field widths.
  localparam int ADDR_W    = 32;
  localparam int BUCKET_W  = 6;
  localparam int TIME_W    = 32;
  localparam int COUNT_W   = 5;
  localparam int WINDOW_W  = 16;
  localparam int MAXREQ_W  = 8;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 16;

  // Register values after reset.
  localparam logic                LIMIT_EN_RST = 1'b0;
  localparam logic [WINDOW_W-1:0] WINDOW_RST   = 16'd60;
  localparam logic [MAXREQ_W-1:0] MAXREQ_RST   = 8'd10;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LIMIT_ENABLE   = 2'd0,
    CFG_WINDOW_SECONDS = 2'd1,
    CFG_MAX_REQUESTS   = 2'd2
  } cfg_idx_e;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_META,
    ST_SCAN,
    ST_WRITE
  } state_e;

  // Request beat.
  typedef struct packed {
    logic [ADDR_W-1:0]   client_ip;
    logic [BUCKET_W-1:0] bucket;
    logic [TIME_W-1:0]   now_seconds;
  } req_t;

  // Result beat.
  typedef struct packed {
    logic               limited;
    logic [COUNT_W-1:0] recent_count;
  } rsp_t;

  // Control of the shared compare and count unit.
  typedef struct packed {
    logic clear;
    logic hit_valid;
  } scan_ctrl_t;

endpackage

>>> hdl/sliding_window_rate_limiter.sv
// Each request passes the META, SCAN and WRITE states in turn; with limiting off SCAN is
// skipped, and the walk in SCAN reads each of the bucket's stored stamps in turn. A new
// request is taken only in IDLE, after the last one has left WRITE, and an output stall
// holds the block in WRITE until the result can be loaded.
// Reset clears the registers and then sweeps the bucket table, one bucket a cycle, before
// the first request is taken; configuration writes are taken at any time.
module sliding_window_rate_limiter #(
  parameter int BUCKETS    = srl_pkg::BUCKETS_DEF,
  parameter int RING_DEPTH = srl_pkg::RING_DEPTH_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [srl_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [srl_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  srl_pkg::req_t                 in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output srl_pkg::rsp_t                 out_data_o
);

  localparam int BW    = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam int SW    = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int FW    = $clog2(RING_DEPTH + 1);
  localparam int SLOTS = BUCKETS * RING_DEPTH;
  localparam int AW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int MW    = srl_pkg::ADDR_W + FW + SW;
  localparam int CW    = (FW > srl_pkg::MAXREQ_W) ? FW : srl_pkg::MAXREQ_W;
  localparam int NB_IN = 2 ** srl_pkg::BUCKET_W;

  // Configuration registers.
  logic                             limit_en_q;
  logic [srl_pkg::WINDOW_W-1:0]     window_q;
  logic [srl_pkg::MAXREQ_W-1:0]     max_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_en_q <= srl_pkg::LIMIT_EN_RST;
      window_q   <= srl_pkg::WINDOW_RST;
      max_q      <= srl_pkg::MAXREQ_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        srl_pkg::CFG_LIMIT_ENABLE:   limit_en_q <= cfg_wdata_i[0];
        srl_pkg::CFG_WINDOW_SECONDS: window_q   <= cfg_wdata_i[srl_pkg::WINDOW_W-1:0];
        srl_pkg::CFG_MAX_REQUESTS:   max_q      <= cfg_wdata_i[srl_pkg::MAXREQ_W-1:0];
        default: ;
      endcase
    end
  end

  // Bucket index wrap table, worked out at elaboration.
  logic [BW-1:0] wrap_lut [NB_IN];
  for (genvar g = 0; g < NB_IN; g++) begin : g_wrap
    assign wrap_lut[g] = BW'(g % BUCKETS);
  end

  srl_pkg::state_e state_q, state_d;

  // Per-request registers.
  logic [srl_pkg::ADDR_W-1:0] addr_q;
  logic [srl_pkg::TIME_W-1:0] now_q;
  logic [srl_pkg::TIME_W-1:0] cutoff_q;
  logic [BW-1:0]              idx_q;
  logic [AW-1:0]              base_q;
  logic                       en_q;
  logic [FW-1:0]              fill_q;
  logic [SW-1:0]              slot_q;
  logic [FW-1:0]              scan_idx_q;
  logic                       pend_q;
  logic [BW-1:0]              clr_q;

  // Output register.
  logic          out_valid_q;
  srl_pkg::rsp_t out_data_q;

  // Memory ports.
  logic          meta_we;
  logic [BW-1:0] meta_waddr;
  logic [MW-1:0] meta_wdata;
  logic [BW-1:0] meta_raddr;
  logic [MW-1:0] meta_rdata;
  logic          stamp_we;
  logic [AW-1:0] stamp_waddr;
  logic [AW-1:0] stamp_raddr;
  logic [srl_pkg::TIME_W-1:0] stamp_rdata;

  logic                  accept;
  logic                  out_free;
  logic                  out_load;
  logic                  scan_issue;
  logic                  limited_w;
  logic                  claim;
  logic [FW-1:0]         scan_cnt;
  logic [FW-1:0]         fill_next;
  logic [SW-1:0]         slot_next;
  srl_pkg::scan_ctrl_t   scan_ctrl;

  // Fields of the metadata word read back for the current bucket.
  logic [srl_pkg::ADDR_W-1:0] meta_key;
  logic [FW-1:0]              meta_fill;
  logic [SW-1:0]              meta_slot;
  assign {meta_key, meta_fill, meta_slot} = meta_rdata;

  assign accept     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign scan_issue = (state_q == srl_pkg::ST_SCAN) && (scan_idx_q < fill_q);
  assign claim      = (meta_fill == '0) || (meta_key != addr_q);
  assign limited_w  = en_q && (CW'(scan_cnt) >= CW'(max_q));
  assign fill_next  = limited_w ? fill_q :
                      ((fill_q < FW'(RING_DEPTH)) ? fill_q + FW'(1) : fill_q);
  assign slot_next  = limited_w ? slot_q :
                      ((slot_q == SW'(RING_DEPTH - 1)) ? '0 : slot_q + SW'(1));

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      srl_pkg::ST_CLEAR: begin
        if (clr_q == BW'(BUCKETS - 1)) state_d = srl_pkg::ST_IDLE;
      end
      srl_pkg::ST_IDLE: begin
        if (accept) state_d = srl_pkg::ST_META;
      end
      srl_pkg::ST_META: begin
        state_d = en_q ? srl_pkg::ST_SCAN : srl_pkg::ST_WRITE;
      end
      srl_pkg::ST_SCAN: begin
        if (!scan_issue && !pend_q) state_d = srl_pkg::ST_WRITE;
      end
      srl_pkg::ST_WRITE: begin
        if (out_free) state_d = srl_pkg::ST_IDLE;
      end
      default: state_d = srl_pkg::ST_CLEAR;
    endcase
  end

  // Sequencer outputs: handshake, memory strobes and scan unit control.
  always_comb begin
    in_stall_o      = 1'b1;
    meta_we         = 1'b0;
    meta_waddr      = idx_q;
    meta_wdata      = {addr_q, fill_next, slot_next};
    stamp_we        = 1'b0;
    out_load        = 1'b0;
    scan_ctrl.clear     = 1'b0;
    scan_ctrl.hit_valid = pend_q;
    case (state_q)
      srl_pkg::ST_CLEAR: begin
        meta_we    = 1'b1;
        meta_waddr = clr_q;
        meta_wdata = '0;
      end
      srl_pkg::ST_IDLE: begin
        in_stall_o      = 1'b0;
        scan_ctrl.clear = accept;
      end
      srl_pkg::ST_WRITE: begin
        out_load = out_free;
        meta_we  = out_free && en_q;
        stamp_we = out_free && en_q && !limited_w;
      end
      default: ;
    endcase
  end

  assign meta_raddr  = wrap_lut[in_data_i.bucket];
  assign stamp_raddr = base_q + AW'(scan_idx_q);
  assign stamp_waddr = base_q + AW'(slot_q);

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= srl_pkg::ST_CLEAR;
      clr_q       <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == srl_pkg::ST_CLEAR) clr_q <= clr_q + BW'(1);
      pend_q <= scan_issue;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Request and walk registers.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      addr_q   <= in_data_i.client_ip;
      now_q    <= in_data_i.now_seconds;
      idx_q    <= wrap_lut[in_data_i.bucket];
      base_q   <= AW'(wrap_lut[in_data_i.bucket]) * AW'(RING_DEPTH);
      en_q     <= limit_en_q;
      cutoff_q <= (in_data_i.now_seconds > srl_pkg::TIME_W'(window_q)) ?
                  in_data_i.now_seconds - srl_pkg::TIME_W'(window_q) : '0;
    end
    if (state_q == srl_pkg::ST_META) begin
      fill_q     <= claim ? '0 : meta_fill;
      slot_q     <= claim ? '0 : meta_slot;
      scan_idx_q <= '0;
    end else if (scan_issue) begin
      scan_idx_q <= scan_idx_q + FW'(1);
    end
    if (out_load) begin
      out_data_q.limited      <= limited_w;
      out_data_q.recent_count <= srl_pkg::COUNT_W'(scan_cnt);
    end
  end

  // Bucket metadata: key, fill count and next ring slot.
  srl_ram #(
    .W (MW),
    .D (BUCKETS)
  ) u_meta_ram (
    .clk_i   (clk_i),
    .we_i    (meta_we),
    .waddr_i (meta_waddr),
    .wdata_i (meta_wdata),
    .raddr_i (meta_raddr),
    .rdata_o (meta_rdata)
  );

  // Timestamp rings of all buckets.
  srl_ram #(
    .W (srl_pkg::TIME_W),
    .D (SLOTS)
  ) u_stamp_ram (
    .clk_i   (clk_i),
    .we_i    (stamp_we),
    .waddr_i (stamp_waddr),
    .wdata_i (now_q),
    .raddr_i (stamp_raddr),
    .rdata_o (stamp_rdata)
  );

  // Shared compare and count unit.
  srl_scan #(
    .FW (FW)
  ) u_scan (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (scan_ctrl),
    .stamp_i  (stamp_rdata),
    .cutoff_i (cutoff_q),
    .count_o  (scan_cnt)
  );

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // A result beat only appears after the write-back step.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == srl_pkg::ST_WRITE))
    else $error("result beat loaded outside write-back");

  // The in-window count never exceeds the number of stamps walked.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == srl_pkg::ST_WRITE) |-> (scan_cnt <= fill_q))
    else $error("in-window count exceeds bucket fill");

  // A request taken while limiting is off leaves both memories untouched.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == srl_pkg::ST_WRITE) && !en_q) |-> (!meta_we && !stamp_we))
    else $error("disabled request wrote table state");

endmodule

>>> hdl/srl_ram.sv
// Generic single write port, single read port RAM with registered read data.
module srl_ram #(
  parameter int W = 32,
  parameter int D = 64,
  localparam int AW = (D > 1) ? $clog2(D) : 1
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [W-1:0]  wdata_i,
  input  logic [AW-1:0] raddr_i,
  output logic [W-1:0]  rdata_o
);

  logic [W-1:0] mem_q [D];
  logic [W-1:0] rdata_q;

  // Write port and registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> hdl/srl_scan.sv
// Shared timestamp comparator and in-window counter used during the ring walk.
module srl_scan #(
  parameter int FW = 5
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  srl_pkg::scan_ctrl_t       ctrl_i,
  input  logic [srl_pkg::TIME_W-1:0] stamp_i,
  input  logic [srl_pkg::TIME_W-1:0] cutoff_i,
  output logic [FW-1:0]             count_o
);

  logic [FW-1:0] count_q;
  logic [FW-1:0] count_d;

  // One stamp per cycle: count it when it is no older than the cutoff.
  always_comb begin
    count_d = count_q;
    if (ctrl_i.clear) begin
      count_d = '0;
    end else if (ctrl_i.hit_valid && (stamp_i >= cutoff_i)) begin
      count_d = count_q + FW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  assign count_o = count_q;

endmodule

>>> dv/sliding_window_rate_limiter_test.sv
// Self-checking testbench for the sliding window rate limiter with its own decision predictor.
module sliding_window_rate_limiter_test;
  import srl_pkg::*;

  localparam int CYCLE_LIMIT   = 400000;
  localparam int DRAIN_CYCLES  = 24;
  localparam int SEGMENT_ITEMS = 30;
  localparam int HOLD_CYCLES   = 300;
  localparam int NUM_BUCKETS   = BUCKETS_DEF;
  localparam int RING_SLOTS    = RING_DEPTH_DEF;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = 2'd3;

  logic                  clk_i       = 1'b0;
  logic                  rst_ni      = 1'b0;
  logic                  cfg_we_i    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i   = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata_i = '0;
  logic                  in_valid_i  = 1'b0;
  logic                  in_stall_o;
  req_t                  in_data_i   = '0;
  logic                  out_valid_o;
  logic                  out_stall_i = 1'b0;
  rsp_t                  out_data_o;

  // Predicted register contents and bucket table.
  logic                 reg_enable;
  logic [WINDOW_W-1:0]  reg_window;
  logic [MAXREQ_W-1:0]  reg_max;
  logic [ADDR_W-1:0]    tbl_owner  [NUM_BUCKETS];
  logic [COUNT_W-1:0]   tbl_fill   [NUM_BUCKETS];
  int unsigned          tbl_next   [NUM_BUCKETS];
  logic [TIME_W-1:0]    tbl_stamps [NUM_BUCKETS][RING_SLOTS];

  // Decisions waiting for their result beat.
  rsp_t verdict_q[$];
  rsp_t seen_verdict;

  int errors       = 0;
  int n_rejected   = 0;
  int n_allowed    = 0;
  int n_bypassed   = 0;
  int n_cfg_writes = 0;
  int cycle_count  = 0;
  int send_idle_pct = 0;
  int stall_pct     = 0;
  int hold_request  = 0;
  int hold_left     = 0;

  // Current owner per bucket and a running wall clock for well-formed traffic.
  logic [ADDR_W-1:0] bucket_client [NUM_BUCKETS];
  logic [TIME_W-1:0] wall_secs;

  sliding_window_rate_limiter uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  // Clock with a period of 20.
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Works out the decision for one request and updates the predicted table.
  function automatic rsp_t predict_decision(input req_t r);
    rsp_t                   d;
    logic [TIME_W-1:0]      cutoff;
    int unsigned            hits;
    logic [BUCKET_W-1:0]    b;
    d = '0;
    b = r.bucket;
    if (!reg_enable) begin
      n_bypassed++;
      return d;
    end
    // A new client or an empty bucket starts a fresh log.
    if (tbl_fill[b] == 0 || tbl_owner[b] != r.client_ip) begin
      tbl_owner[b] = r.client_ip;
      tbl_fill[b]  = '0;
      tbl_next[b]  = 0;
    end
    cutoff = (r.now_seconds > TIME_W'(reg_window)) ?
             r.now_seconds - TIME_W'(reg_window) : '0;
    hits = 0;
    for (int i = 0; i < tbl_fill[b]; i++) begin
      if (tbl_stamps[b][i] >= cutoff) hits++;
    end
    d.limited      = (hits >= reg_max);
    d.recent_count = COUNT_W'(hits);
    // An allowed request is logged; a full ring overwrites its oldest slot.
    if (!d.limited) begin
      tbl_stamps[b][tbl_next[b]] = r.now_seconds;
      tbl_next[b] = (tbl_next[b] + 1) % RING_SLOTS;
      if (tbl_fill[b] < RING_SLOTS) tbl_fill[b] = tbl_fill[b] + 1'b1;
      n_allowed++;
    end else begin
      n_rejected++;
    end
    return d;
  endfunction

  function automatic req_t make_req(input logic [ADDR_W-1:0] addr,
                                    input logic [BUCKET_W-1:0] bkt,
                                    input logic [TIME_W-1:0] secs);
    req_t r;
    r.client_ip   = addr;
    r.bucket      = bkt;
    r.now_seconds = secs;
    return r;
  endfunction

  // Writes one register and mirrors it; the enable drops in the next cycle.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_LIMIT_ENABLE:   reg_enable = data[0];
      CFG_WINDOW_SECONDS: reg_window = data[WINDOW_W-1:0];
      CFG_MAX_REQUESTS:   reg_max    = data[MAXREQ_W-1:0];
      default: ;
    endcase
    n_cfg_writes++;
    @(posedge clk_i);
  endtask

  // Offers one request beat, with random idle cycles first, and logs its decision on accept.
  task automatic offer_request(input req_t r);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= r;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    verdict_q.push_back(predict_decision(r));
  endtask

  // Stops offering and waits until every decision has come back.
  task automatic drain_results;
    in_valid_i <= 1'b0;
    while (verdict_q.size() != 0) @(posedge clk_i);
  endtask

  // Limiting off after reset: every request passes with a zero count.
  task automatic test_disabled;
    offer_request(make_req(32'hFFFF_FFFF, 6'd63, 32'hFFFF_FFFF));
    offer_request(make_req(32'h0000_0000, 6'd0, 32'h0000_0000));
    drain_results();
  endtask

  // Reset window and maximum: ten early requests pass, the eleventh is rejected.
  task automatic test_default_limit;
    write_reg(CFG_LIMIT_ENABLE, 16'hFFFF);
    for (int i = 0; i < 11; i++) offer_request(make_req(32'hFFFF_FFFF, 6'd63, 32'd5));
    drain_results();
  endtask

  // Widest window and largest maximum: the ring fills and then wraps.
  task automatic test_full_ring;
    write_reg(CFG_WINDOW_SECONDS, 16'hFFFF);
    write_reg(CFG_MAX_REQUESTS, 16'hFFFF);
    for (int i = 0; i < 7; i++) offer_request(make_req(32'hFFFF_FFFF, 6'd63, 32'd20));
    offer_request(make_req(32'hFFFF_FFFF, 6'd63, 32'hFFFF_FFFF));
    drain_results();
  endtask

  // Zero maximum rejects all, a new client claims a bucket, zero window, unused index.
  task automatic test_zero_max;
    write_reg(CFG_MAX_REQUESTS, 16'hFF00);
    write_reg(CFG_WINDOW_SECONDS, 16'h0000);
    write_reg(CFG_UNUSED_IDX, 16'h0001);
    offer_request(make_req(32'h0000_0000, 6'd63, 32'hFFFF_FFFF));
    drain_results();
    write_reg(CFG_MAX_REQUESTS, 16'h0001);
    offer_request(make_req(32'h0000_0000, 6'd0, 32'h0000_0000));
    offer_request(make_req(32'h0000_0000, 6'd0, 32'h0000_0000));
    drain_results();
  endtask

  // The output is held off for a long stretch while requests keep coming.
  task automatic test_backpressure;
    write_reg(CFG_WINDOW_SECONDS, 16'd100);
    write_reg(CFG_MAX_REQUESTS, 16'd8);
    hold_request = HOLD_CYCLES;
    for (int i = 0; i < 12; i++) offer_request(make_req(32'h0A00_0001, 6'd7, 32'd1000 + i));
    drain_results();
  endtask

  // Segments of traffic on a few busy buckets under a fresh random setting each.
  task automatic run_random_phase(input int items);
    int                   done;
    int                   pick;
    logic [BUCKET_W-1:0]  pool [3];
    logic [BUCKET_W-1:0]  b;
    logic [WINDOW_W-1:0]  win_v;
    logic [MAXREQ_W-1:0]  max_v;
    logic [CFG_DATA_W-1:0] junk;
    done = 0;
    while (done < items) begin
      drain_results();
      // New setting, extremes included, with junk in the unused data bits.
      case ($urandom_range(9))
        0: win_v = '0;
        1: win_v = '1;
        2: win_v = WINDOW_W'($urandom_range(65535));
        default: win_v = WINDOW_W'($urandom_range(40));
      endcase
      case ($urandom_range(9))
        0: max_v = '0;
        1: max_v = '1;
        2: max_v = MAXREQ_W'($urandom_range(255));
        default: max_v = MAXREQ_W'($urandom_range(17, 1));
      endcase
      junk = CFG_DATA_W'($urandom_range(65535));
      write_reg(CFG_LIMIT_ENABLE, {junk[CFG_DATA_W-1:1], ($urandom_range(9) != 0)});
      write_reg(CFG_WINDOW_SECONDS, win_v);
      write_reg(CFG_MAX_REQUESTS, {junk[CFG_DATA_W-1:MAXREQ_W], max_v});
      if ($urandom_range(3) == 0) begin
        write_reg(CFG_UNUSED_IDX, CFG_DATA_W'($urandom_range(65535)));
      end
      foreach (pool[i]) pool[i] = BUCKET_W'($urandom_range(NUM_BUCKETS - 1));
      // Time jumps now and then to the very start or the wrap of the clock.
      case ($urandom_range(9))
        0: wall_secs = $urandom_range(50);
        1: wall_secs = 32'hFFFF_FFFF - $urandom_range(100);
        default: wall_secs = wall_secs + $urandom_range(300);
      endcase
      for (int k = 0; k < SEGMENT_ITEMS; k++) begin
        pick = $urandom_range(99);
        b = pool[$urandom_range(2)];
        if (pick < 90) begin
          // Mostly the owner returns; sometimes a new client takes the bucket over.
          if (pick >= 80) bucket_client[b] = $urandom;
          wall_secs = wall_secs + $urandom_range(3);
          offer_request(make_req(bucket_client[b], b, wall_secs));
        end else begin
          offer_request(make_req($urandom, BUCKET_W'($urandom_range(NUM_BUCKETS - 1)),
                                 $urandom));
        end
      end
      done += SEGMENT_ITEMS;
    end
  endtask

  // Output stall: a requested long hold first, otherwise random stalls.
  always @(posedge clk_i) begin
    if (hold_request != 0) begin
      hold_left    = hold_request;
      hold_request = 0;
    end
    if (hold_left != 0) begin
      out_stall_i <= 1'b1;
      hold_left--;
    end else begin
      out_stall_i <= ($urandom_range(99) < stall_pct);
    end
  end

  // Each accepted result beat is compared with the oldest waiting decision.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (verdict_q.size() == 0) begin
        $display("%0t: result with nothing expected, actual limited %0b count %0d",
                 $time, out_data_o.limited, out_data_o.recent_count);
        errors++;
      end else begin
        seen_verdict = verdict_q.pop_front();
        if (out_data_o.limited !== seen_verdict.limited) begin
          $display("%0t: limited mismatch, expected %0b, actual %0b",
                   $time, seen_verdict.limited, out_data_o.limited);
          errors++;
        end
        if (out_data_o.recent_count !== seen_verdict.recent_count) begin
          $display("%0t: recent_count mismatch, expected %0d, actual %0d",
                   $time, seen_verdict.recent_count, out_data_o.recent_count);
          errors++;
        end
      end
    end
  end

  // Watchdog on the total run length.
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("Run stopped after %0d cycles without finishing.", CYCLE_LIMIT);
    $display("Simulation FAILED");
    $finish;
  end

  // Test sequence.
  initial begin
    reg_enable = LIMIT_EN_RST;
    reg_window = WINDOW_RST;
    reg_max    = MAXREQ_RST;
    foreach (tbl_fill[i]) begin
      tbl_owner[i]     = '0;
      tbl_fill[i]      = '0;
      tbl_next[i]      = 0;
      bucket_client[i] = $urandom;
    end
    wall_secs = $urandom;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_disabled();
    test_default_limit();
    test_full_ring();
    test_zero_max();
    test_backpressure();

    send_idle_pct = 34;
    stall_pct     = 57;
    run_random_phase(330);
    send_idle_pct = 57;
    stall_pct     = 34;
    run_random_phase(330);
    send_idle_pct = 0;
    stall_pct     = 0;
    run_random_phase(340);

    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    $display("Requests checked: %0d rejected, %0d allowed and logged, %0d passed while off.",
             n_rejected, n_allowed, n_bypassed);
    $display("Register writes: %0d, with one long output hold; mismatches: %0d.",
             n_cfg_writes, errors);
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

>>> sim.f
hdl/srl_pkg.sv
hdl/srl_ram.sv
hdl/srl_scan.sv
hdl/sliding_window_rate_limiter.sv
dv/sliding_window_rate_limiter_test.sv
